// ===== hw/rtl/ipcqd_pkg.sv =====
// shared types and constants for the int8 per-channel quantized dot block
// no dependencies; imported by every module of the block
package ipcqd_pkg;

  // feature limit and derived widths
  localparam int MAX_FEATURES = 65536;
  localparam int CNT_W        = $clog2(MAX_FEATURES + 2);
  localparam int ACT_W        = 8;
  localparam int DIFF_W       = ACT_W + 1;
  localparam int MACP_W       = 2 * DIFF_W;
  localparam int SUM_W        = 40;
  localparam int SCALE_W      = 32;
  localparam int COMB_W       = 2 * SCALE_W;
  localparam int MAG_W        = SUM_W;
  localparam int PROD_W       = MAG_W + COMB_W;
  localparam int RES_W        = 48;
  localparam int FRAC_SH      = 32;

  // input word layout
  localparam int IN_ACT_LSB   = 0;
  localparam int IN_WGT_LSB   = IN_ACT_LSB + ACT_W;
  localparam int IN_CZP_LSB   = IN_WGT_LSB + ACT_W;
  localparam int IN_CSC_LSB   = IN_CZP_LSB + ACT_W;
  localparam int IN_BIAS_LSB  = IN_CSC_LSB + SCALE_W;
  localparam int IN_DATA_W    = IN_BIAS_LSB + RES_W;

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32'h0100_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_ZP   = 2'd0,
    CFG_SCALE      = 2'd1,
    CFG_BIAS_EN    = 2'd2
  } cfg_idx_t;

  // result limits
  localparam logic signed [RES_W-1:0] POS_LIM = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] NEG_LIM = {1'b1, {(RES_W-1){1'b0}}};

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [ACT_W-1:0]   input_zero_point;
    logic [SCALE_W-1:0]        scale_ratio;
    logic                      bias_enable;
  } ipcqd_cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   sum;
    logic                      cnt_ovf;
    logic [SCALE_W-1:0]        channel_scale;
    logic signed [RES_W-1:0]   bias_value;
  } ipcqd_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_RND,
    BK_BIAS,
    BK_OUT
  } back_state_t;

endpackage

// ===== hw/rtl/int8_per_channel_quantized_dot.sv =====
// int8 per-channel quantized dot product: one element pair a cycle while the job queue
// has room, one result per run; after the accepted last pair the job passes the queue,
// the 7 multiplier steps of the shared 32x32 unit, rounding and bias to out_tvalid, plus
// any wait on out_tready; the back end takes a new job only once its result has left,
// so runs shorter than its work per job stall input once the 2-entry job queue fills
// reset (rst_n low, synchronous): sums, counts, queue and sequencer clear; config returns
// to zero point 0, scale ratio 1.0, bias off
module int8_per_channel_quantized_dot (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipcqd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipcqd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // element words
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // activation, weight_value, channel_zero_point, channel_scale, bias_value
  input  logic [ipcqd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  // result words
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // result_value
  output logic [ipcqd_pkg::RES_W-1:0]          out_tdata,
  // overflow
  output logic                                 out_tuser
);
  import ipcqd_pkg::*;

  ipcqd_cfg_t cfg_r;
  ipcqd_job_t push_job, head_job;
  logic       q_push, q_pop, q_full, q_empty;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_zero_point <= '0;
      cfg_r.scale_ratio      <= SCALE_RESET;
      cfg_r.bias_enable      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INPUT_ZP: cfg_r.input_zero_point <= cfg_data[ACT_W-1:0];
        CFG_SCALE:    cfg_r.scale_ratio      <= cfg_data[SCALE_W-1:0];
        CFG_BIAS_EN:  cfg_r.bias_enable      <= cfg_data[0];
        default:      cfg_r                  <= cfg_r;
      endcase
    end
  end

  // accumulate front
  ipcqd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // job queue
  ipcqd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // scaling back end
  ipcqd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .head_job   (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // queue occupancy is consistent
  assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
    else $error("job queue reports full and empty together");

  // a finished run is waiting in the queue on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !q_empty)
    else $error("last pair accepted but no job queued");

  // back end takes a new job only once its result word has left
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !out_tvalid)
    else $error("job popped while a result word is pending");

endmodule

// ===== hw/rtl/ipcqd_front.sv =====
// front end: accepts element words, runs the multiply-accumulate per pair
// depends on ipcqd_pkg; pushes one job per finished dot product into the queue
module ipcqd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipcqd_pkg::ipcqd_cfg_t               cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ipcqd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  logic                                q_full,
  output logic                                q_push,
  output ipcqd_pkg::ipcqd_job_t               q_job
);
  import ipcqd_pkg::*;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt, sum_upd;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_upd;
  logic signed [ACT_W-1:0]  act, wgt, czp;
  logic signed [DIFF_W-1:0] a_diff, w_diff;
  logic signed [MACP_W-1:0] macp;
  logic                     accept;

  // field unpack
  assign act = in_tdata[IN_ACT_LSB +: ACT_W];
  assign wgt = in_tdata[IN_WGT_LSB +: ACT_W];
  assign czp = in_tdata[IN_CZP_LSB +: ACT_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // zero point removal and product
  assign a_diff = DIFF_W'(act) - DIFF_W'(cfg.input_zero_point);
  assign w_diff = DIFF_W'(wgt) - DIFF_W'(czp);
  assign macp   = a_diff * w_diff;

  // accumulate until the feature limit, then pin the count past it
  always_comb begin
    if (cnt_r < CNT_W'(MAX_FEATURES)) begin
      sum_upd = sum_r + SUM_W'(macp);
      cnt_upd = cnt_r + CNT_W'(1);
    end else begin
      sum_upd = sum_r;
      cnt_upd = CNT_W'(MAX_FEATURES + 1);
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_tlast) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // job handed to the back end on the last pair
  assign q_push              = accept && in_tlast;
  assign q_job.sum           = sum_upd;
  assign q_job.cnt_ovf       = cnt_upd > CNT_W'(MAX_FEATURES);
  assign q_job.channel_scale = in_tdata[IN_CSC_LSB +: SCALE_W];
  assign q_job.bias_value    = in_tdata[IN_BIAS_LSB +: RES_W];

endmodule

// ===== hw/rtl/ipcqd_queue.sv =====
// short job queue between the accumulate front and the scaling back end
// depends on ipcqd_pkg for the job type and depth
module ipcqd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipcqd_pkg::ipcqd_job_t push_job,
  input  logic                  pop,
  output ipcqd_pkg::ipcqd_job_t head_job,
  output logic                  full,
  output logic                  empty
);
  import ipcqd_pkg::*;

  ipcqd_job_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign empty    = cnt_r == '0;
  assign head_job = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ipcqd_back.sv =====
// back end: rescales a finished sum to Q32.16, adds bias, saturates, emits the word
// depends on ipcqd_pkg; one shared 32x32 multiplier stepped by a small sequencer
module ipcqd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipcqd_pkg::ipcqd_cfg_t         cfg,
  input  logic                          q_empty,
  input  ipcqd_pkg::ipcqd_job_t         head_job,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ipcqd_pkg::RES_W-1:0]   out_tdata,
  output logic                          out_tuser
);
  import ipcqd_pkg::*;

  // multiplier steps
  localparam logic [2:0] STEP_COMB    = 3'd0;
  localparam logic [2:0] STEP_COMB_LD = 3'd1;
  localparam logic [2:0] STEP_M0      = 3'd2;
  localparam logic [2:0] STEP_M1      = 3'd3;
  localparam logic [2:0] STEP_M2      = 3'd4;
  localparam logic [2:0] STEP_M3      = 3'd5;
  localparam logic [2:0] STEP_FLUSH   = 3'd6;

  back_state_t               state_r, state_nxt;
  logic [2:0]                step_r, step_nxt;

  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic [SCALE_W-1:0]        cscale_r;
  logic signed [RES_W-1:0]   bias_r;
  logic                      ovf_r;
  logic [COMB_W-1:0]         comb_r;
  logic [COMB_W-1:0]         prod_r;
  logic [PROD_W-1:0]         acc_r;
  logic signed [RES_W-1:0]   val_r;

  logic [SCALE_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]         prod_ext, addend;
  logic [RES_W:0]            q_rnd, mag_rnd;
  logic                      rnd_sat, rnd_clip;
  logic signed [RES_W-1:0]   rnd_val;
  logic signed [RES_W:0]     bias_sum;
  logic                      bias_clip;
  logic signed [RES_W-1:0]   bias_val;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= STEP_COMB;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    q_pop      = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          step_nxt  = STEP_COMB;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_FLUSH) begin
          state_nxt = BK_RND;
        end
      end
      BK_RND:  state_nxt = BK_BIAS;
      BK_BIAS: state_nxt = BK_OUT;
      BK_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // shared multiplier operands: channel scale times ratio, then four partials
  always_comb begin
    unique case (step_r)
      STEP_COMB: begin
        mul_a = cscale_r;
        mul_b = cfg.scale_ratio;
      end
      STEP_M0: begin
        mul_a = mag_r[SCALE_W-1:0];
        mul_b = comb_r[SCALE_W-1:0];
      end
      STEP_M1: begin
        mul_a = mag_r[SCALE_W-1:0];
        mul_b = comb_r[COMB_W-1:SCALE_W];
      end
      STEP_M2: begin
        mul_a = SCALE_W'(mag_r[MAG_W-1:SCALE_W]);
        mul_b = comb_r[SCALE_W-1:0];
      end
      STEP_M3: begin
        mul_a = SCALE_W'(mag_r[MAG_W-1:SCALE_W]);
        mul_b = comb_r[COMB_W-1:SCALE_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product alignment, one step behind the multiplier
  assign prod_ext = PROD_W'(prod_r);
  always_comb begin
    case (step_r) inside
      STEP_M1:          addend = prod_ext;
      STEP_M2, STEP_M3: addend = prod_ext << SCALE_W;
      STEP_FLUSH:       addend = prod_ext << COMB_W;
      default:          addend = '0;
    endcase
  end

  // round half away from zero on the magnitude, then clip to 48 bits
  assign q_rnd   = {1'b0, acc_r[FRAC_SH +: RES_W]} + (RES_W+1)'(acc_r[FRAC_SH-1]);
  assign rnd_sat = |acc_r[PROD_W-1:FRAC_SH+RES_W];
  assign mag_rnd = rnd_sat ? {1'b1, {RES_W{1'b0}}} : q_rnd;

  always_comb begin
    if (neg_r) begin
      rnd_clip = mag_rnd[RES_W] || (mag_rnd[RES_W-1] && (|mag_rnd[RES_W-2:0]));
      rnd_val  = rnd_clip ? NEG_LIM : -$signed(mag_rnd[RES_W-1:0]);
    end else begin
      rnd_clip = mag_rnd[RES_W] || mag_rnd[RES_W-1];
      rnd_val  = rnd_clip ? POS_LIM : $signed(mag_rnd[RES_W-1:0]);
    end
  end

  // bias add with saturation
  assign bias_sum  = {val_r[RES_W-1], val_r} + {bias_r[RES_W-1], bias_r};
  assign bias_clip = bias_sum[RES_W] != bias_sum[RES_W-1];
  assign bias_val  = bias_clip ? (bias_sum[RES_W] ? NEG_LIM : POS_LIM)
                               : bias_sum[RES_W-1:0];

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_r    <= head_job.sum[SUM_W-1];
      mag_r    <= head_job.sum[SUM_W-1] ? MAG_W'(-head_job.sum) : MAG_W'(head_job.sum);
      cscale_r <= head_job.channel_scale;
      bias_r   <= head_job.bias_value;
      ovf_r    <= head_job.cnt_ovf;
      acc_r    <= '0;
    end
    if (state_r == BK_MUL) begin
      prod_r <= COMB_W'(mul_a * mul_b);
      if (step_r == STEP_COMB_LD) begin
        comb_r <= prod_r;
      end
      acc_r <= acc_r + addend;
    end
    if (state_r == BK_RND) begin
      val_r <= rnd_val;
      ovf_r <= ovf_r | rnd_sat | rnd_clip;
    end
    if (state_r == BK_BIAS && cfg.bias_enable) begin
      val_r <= bias_val;
      ovf_r <= ovf_r | bias_clip;
    end
  end

  assign out_tdata = val_r;
  assign out_tuser = ovf_r;

endmodule
